[rtl/gtoc_pkg.sv]
`default_nettype none
package gtoc_pkg;

   // field widths
   localparam int UNIT_W = 3;
   localparam int MULT_W = 5;
   localparam int STEP_W = 21;
   localparam int SEC_W  = 26;
   localparam int TEXT_W = 64;
   localparam int CHAR_W = 8;
   localparam int NCHARS = TEXT_W / CHAR_W;

   // unit codes and limits
   localparam logic [UNIT_W-1:0] UNIT_OFF = 3'd7;
   localparam int                MULT_MAX = 31;

   // status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_RANGE     = 2'd1;
   localparam logic [1:0] ST_MALFORMED = 2'd2;

   // character codes
   localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;
   localparam logic [CHAR_W-1:0] CH_ONE  = 8'h31;

   // unit tables, coarsest unit first
   localparam int TAU_CNT = 7;
   localparam int ACT_CNT = 3;

   localparam logic [STEP_W-1:0] TAU_STEP [TAU_CNT] = '{
      21'(320 * 3600), 21'(10 * 3600), 21'd3600, 21'd600, 21'd60, 21'd30, 21'd2
   };
   localparam logic [UNIT_W-1:0] TAU_CODE [TAU_CNT] = '{
      3'd6, 3'd2, 3'd1, 3'd0, 3'd5, 3'd4, 3'd3
   };
   localparam logic [STEP_W-1:0] ACT_STEP [ACT_CNT] = '{
      21'(6 * 60), 21'd60, 21'd2
   };
   localparam logic [UNIT_W-1:0] ACT_CODE [ACT_CNT] = '{
      3'd2, 3'd1, 3'd0
   };

   // input item
   typedef struct packed {
      logic              kind;
      logic              is_tau;
      logic [31:0]       seconds;
      logic [TEXT_W-1:0] timer_text;
      logic [CHAR_W-1:0] text_end;
   } req_type;

   // after stage 1: text checked, octet assembled
   typedef struct packed {
      logic        kind;
      logic        is_tau;
      logic [31:0] seconds;
      logic        sec_zero;
      logic        text_ok;
      logic [7:0]  octet;
   } front_type;

   // after stage 2: per-unit matches and decoded duration
   typedef struct packed {
      logic                            kind;
      logic                            is_tau;
      logic                            sec_zero;
      logic                            text_ok;
      logic [7:0]                      octet;
      logic [TAU_CNT-1:0]              tau_hit;
      logic [TAU_CNT-1:0][MULT_W-1:0]  tau_mult;
      logic [ACT_CNT-1:0]              act_hit;
      logic [ACT_CNT-1:0][MULT_W-1:0]  act_mult;
      logic                            unit_ok;
      logic [SEC_W-1:0]                dec_seconds;
   } match_type;

   // result item
   typedef struct packed {
      logic [1:0]       status;
      logic [7:0]       timer_octet;
      logic [SEC_W-1:0] seconds_value;
   } rsp_type;

   typedef struct packed {
      logic              ok;
      logic [STEP_W-1:0] step;
   } unit_type;

   // step of a unit code in the selected table
   function automatic unit_type step_of(input logic tau, input logic [UNIT_W-1:0] unit);
      unit_type r;
      r = '0;
      if (tau) begin
         for (int i = 0; i < TAU_CNT; i++) begin
            if (TAU_CODE[i] == unit) begin
               r.ok   = 1'b1;
               r.step = TAU_STEP[i];
            end
         end
      end else begin
         for (int i = 0; i < ACT_CNT; i++) begin
            if (ACT_CODE[i] == unit) begin
               r.ok   = 1'b1;
               r.step = ACT_STEP[i];
            end
         end
      end
      return r;
   endfunction

endpackage
`default_nettype wire

[rtl/gprs_timer_octet_codec.sv]
`default_nettype none
// Channel | Dir | Ports                                | Payload
// req     | in  | req_tvalid/tready/tdata/tuser        | tdata: seconds, timer_text, text_end
//         |     |                                      | tuser: kind, is_tau
// rsp     | out | rsp_tvalid/tready/tdata/tuser        | tdata: timer_octet, seconds_value
//         |     |                                      | tuser: status
//
// One item per cycle sustained while rsp_tready is high; items pass through the check, match and select stages.
// The per-unit multiple compare in the middle stage sets the cycle time.
// Reset clears the stage valid bits only; payload registers are not reset.
// A stalled result holds; each stage takes a new item when empty or when
// the stage after it moves, so bubbles close up under back-pressure.
module gprs_timer_octet_codec (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [103:0] req_tdata,  // seconds[31:0], timer_text[95:32], text_end[103:96]
   input  wire logic [1:0]   req_tuser,  // kind[0], is_tau[1]
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [39:0]       rsp_tdata,  // timer_octet[7:0], seconds_value[33:8], zero pad
   output logic [1:0]        rsp_tuser   // status[1:0]
);

   gtoc_pkg::req_type   req;
   gtoc_pkg::front_type s1_data;
   gtoc_pkg::match_type s2_data;
   gtoc_pkg::rsp_type   rsp;
   logic                s1_valid;
   logic                s1_ready;
   logic                s2_valid;
   logic                s2_ready;

   // unpack input item
   assign req.kind       = req_tuser[0];
   assign req.is_tau     = req_tuser[1];
   assign req.seconds    = req_tdata[31:0];
   assign req.timer_text = req_tdata[95:32];
   assign req.text_end   = req_tdata[103:96];

   gtoc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (req),
      .out_valid (s1_valid),
      .out_ready (s1_ready),
      .out_data  (s1_data)
   );

   gtoc_match u_match (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_ready  (s1_ready),
      .in_data   (s1_data),
      .out_valid (s2_valid),
      .out_ready (s2_ready),
      .out_data  (s2_data)
   );

   gtoc_select u_select (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid),
      .in_ready  (s2_ready),
      .in_data   (s2_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp)
   );

   // pack result item
   assign rsp_tuser = rsp.status;
   assign rsp_tdata = {6'd0, rsp.seconds_value, rsp.timer_octet};

   // an unrepresentable duration carries no octet and no seconds
   a_range_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == gtoc_pkg::ST_RANGE |-> rsp_tdata == '0)
      else $error("range status with nonzero payload");

   // the deactivated unit always reports zero seconds
   a_off_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == gtoc_pkg::ST_OK && rsp_tdata[7:5] == gtoc_pkg::UNIT_OFF
      |-> rsp_tdata[33:8] == '0)
      else $error("deactivated unit with nonzero seconds");

   // no undefined status code leaves the block
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser == gtoc_pkg::ST_OK || rsp_tuser == gtoc_pkg::ST_RANGE ||
                     rsp_tuser == gtoc_pkg::ST_MALFORMED)
      else $error("undefined status code");

   // a full pipeline behind a stalled output takes no new item
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      s1_valid && s2_valid && rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("item taken while pipeline full and stalled");

endmodule
`default_nettype wire

[rtl/gtoc_front.sv]
`default_nettype none
// Stage 1: text check, octet assembly, zero test
module gtoc_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  wire gtoc_pkg::req_type  in_data,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output gtoc_pkg::front_type     out_data
);

   logic                valid_ff;
   gtoc_pkg::front_type data_ff;
   gtoc_pkg::front_type data_in;

   assign in_ready = !valid_ff || out_ready;

   // each character must be '0' or '1', ninth must be NUL
   always_comb begin
      logic                        ok;
      logic [gtoc_pkg::CHAR_W-1:0] ch;
      ok = 1'b1;
      data_in.octet = '0;
      for (int i = 0; i < gtoc_pkg::NCHARS; i++) begin
         ch = in_data.timer_text[gtoc_pkg::TEXT_W-1-gtoc_pkg::CHAR_W*i -: gtoc_pkg::CHAR_W];
         if (ch != gtoc_pkg::CH_ZERO && ch != gtoc_pkg::CH_ONE) ok = 1'b0;
         data_in.octet[7-i] = ch[0];
      end
      data_in.kind     = in_data.kind;
      data_in.is_tau   = in_data.is_tau;
      data_in.seconds  = in_data.seconds;
      data_in.sec_zero = (in_data.seconds == '0);
      data_in.text_ok  = ok && (in_data.text_end == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule
`default_nettype wire

[rtl/gtoc_match.sv]
`default_nettype none
// Stage 2: exact-multiple match per unit, decode step times multiplier
module gtoc_match (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire gtoc_pkg::front_type  in_data,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output gtoc_pkg::match_type       out_data
);

   logic                valid_ff;
   gtoc_pkg::match_type data_ff;
   gtoc_pkg::match_type data_in;

   assign in_ready = !valid_ff || out_ready;

   // a unit hits when seconds equals step times some multiplier 1..31
   always_comb begin
      gtoc_pkg::unit_type u;
      data_in.tau_hit  = '0;
      data_in.tau_mult = '0;
      data_in.act_hit  = '0;
      data_in.act_mult = '0;
      for (int k = 0; k < gtoc_pkg::TAU_CNT; k++) begin
         for (int m = 1; m <= gtoc_pkg::MULT_MAX; m++) begin
            if (in_data.seconds == 32'(gtoc_pkg::TAU_STEP[k]) * 32'(m)) begin
               data_in.tau_hit[k]  = 1'b1;
               data_in.tau_mult[k] = gtoc_pkg::MULT_W'(m);
            end
         end
      end
      for (int k = 0; k < gtoc_pkg::ACT_CNT; k++) begin
         for (int m = 1; m <= gtoc_pkg::MULT_MAX; m++) begin
            if (in_data.seconds == 32'(gtoc_pkg::ACT_STEP[k]) * 32'(m)) begin
               data_in.act_hit[k]  = 1'b1;
               data_in.act_mult[k] = gtoc_pkg::MULT_W'(m);
            end
         end
      end

      // decode side: unit lookup and scale
      u = gtoc_pkg::step_of(in_data.is_tau, in_data.octet[7:5]);
      data_in.unit_ok     = u.ok;
      data_in.dec_seconds = gtoc_pkg::SEC_W'(u.step) *
                            gtoc_pkg::SEC_W'(in_data.octet[gtoc_pkg::MULT_W-1:0]);

      data_in.kind     = in_data.kind;
      data_in.is_tau   = in_data.is_tau;
      data_in.sec_zero = in_data.sec_zero;
      data_in.text_ok  = in_data.text_ok;
      data_in.octet    = in_data.octet;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule
`default_nettype wire

[rtl/gtoc_select.sv]
`default_nettype none
// Stage 3: coarsest-unit pick, status and result register
module gtoc_select (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire gtoc_pkg::match_type  in_data,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output gtoc_pkg::rsp_type         out_data
);

   logic              valid_ff;
   gtoc_pkg::rsp_type data_ff;
   gtoc_pkg::rsp_type data_in;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      logic                        found;
      logic [gtoc_pkg::UNIT_W-1:0] code;
      logic [gtoc_pkg::MULT_W-1:0] mult;
      found = 1'b0;
      code  = '0;
      mult  = '0;
      // walk fine to coarse so the coarsest hit is left standing
      if (in_data.is_tau) begin
         for (int k = gtoc_pkg::TAU_CNT - 1; k >= 0; k--) begin
            if (in_data.tau_hit[k]) begin
               found = 1'b1;
               code  = gtoc_pkg::TAU_CODE[k];
               mult  = in_data.tau_mult[k];
            end
         end
      end else begin
         for (int k = gtoc_pkg::ACT_CNT - 1; k >= 0; k--) begin
            if (in_data.act_hit[k]) begin
               found = 1'b1;
               code  = gtoc_pkg::ACT_CODE[k];
               mult  = in_data.act_mult[k];
            end
         end
      end

      data_in = '0;
      if (!in_data.kind) begin
         // encode
         priority if (in_data.sec_zero) begin
            data_in.status      = gtoc_pkg::ST_OK;
            data_in.timer_octet = {gtoc_pkg::UNIT_OFF, gtoc_pkg::MULT_W'(0)};
         end else if (found) begin
            data_in.status      = gtoc_pkg::ST_OK;
            data_in.timer_octet = {code, mult};
         end else begin
            data_in.status      = gtoc_pkg::ST_RANGE;
         end
      end else begin
         // decode
         priority if (!in_data.text_ok) begin
            data_in.status        = gtoc_pkg::ST_MALFORMED;
         end else if (in_data.octet[7:5] == gtoc_pkg::UNIT_OFF) begin
            data_in.status        = gtoc_pkg::ST_OK;
            data_in.timer_octet   = in_data.octet;
         end else if (in_data.unit_ok) begin
            data_in.status        = gtoc_pkg::ST_OK;
            data_in.timer_octet   = in_data.octet;
            data_in.seconds_value = in_data.dec_seconds;
         end else begin
            data_in.status        = gtoc_pkg::ST_MALFORMED;
            data_in.timer_octet   = in_data.octet;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule
`default_nettype wire
